@@ src/spq_pkg.sv @@
// sorted priority queue: shared types, codes and default sizes
// no dependencies; imported by spq_cell, sorted_priority_queue_top, spq_checker and the testbench top
`default_nettype none

package spq_pkg;

	localparam int DEPTH_DEF          = 16;
	localparam int DATA_WIDTH_DEF     = 32;
	localparam int PRIORITY_WIDTH_DEF = 32;

	// operation codes on the input channel; six and seven mean nothing
	typedef enum logic [2:0] {
		OP_INSERT   = 3'd0,
		OP_EXTRACT  = 3'd1,
		OP_REMOVE   = 3'd2,
		OP_CHANGE   = 3'd3,
		OP_CONTAINS = 3'd4,
		OP_CLEAR    = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// command broadcast to every cell of the row
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_EXTRACT,
		CELL_REMOVE
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     occupied;
	} cell_ctl_t;

	// controller state: normal running, or second half of a change key
	typedef enum logic {
		S_RUN,
		S_REKEY
	} state_t;

endpackage

`default_nettype wire

@@ src/spq_cell.sv @@
// sorted priority queue: one cell of the sorted row (one entry)
// depends on spq_pkg; instantiated DEPTH times by sorted_priority_queue_top
`default_nettype none

module spq_cell import spq_pkg::*; #(
	parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
	parameter int PRIORITY_WIDTH = PRIORITY_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire cell_ctl_t                        ctl,
	input  wire logic        [DATA_WIDTH-1:0]     cmd_data,
	input  wire logic signed [PRIORITY_WIDTH-1:0] cmd_priority,
	input  wire logic        [DATA_WIDTH-1:0]     left_data,
	input  wire logic signed [PRIORITY_WIDTH-1:0] left_priority,
	input  wire logic                             left_ge,
	input  wire logic        [DATA_WIDTH-1:0]     right_data,
	input  wire logic signed [PRIORITY_WIDTH-1:0] right_priority,
	input  wire logic                             later_in,
	input  wire logic                             any_match,
	output logic             [DATA_WIDTH-1:0]     data_q,
	output logic signed      [PRIORITY_WIDTH-1:0] priority_q,
	output logic                                  ge,
	output logic                                  later_out
);

	logic                             match;
	logic                             load;
	logic        [DATA_WIDTH-1:0]     data_d;
	logic signed [PRIORITY_WIDTH-1:0] priority_d;

	// new priority goes in front of this entry (free cells count as infinite)
	assign ge        = !ctl.occupied || (cmd_priority <= priority_q);
	assign match     = ctl.occupied && (data_q == cmd_data);
	assign later_out = match || later_in;

	always_comb begin
		load       = 1'b0;
		data_d     = data_q;
		priority_d = priority_q;
		unique case (ctl.op)
			CELL_INSERT: begin
				if (ge) begin
					load = 1'b1;
					if (left_ge) begin
						data_d     = left_data;
						priority_d = left_priority;
					end else begin
						data_d     = cmd_data;
						priority_d = cmd_priority;
					end
				end
			end
			CELL_EXTRACT: begin
				load       = 1'b1;
				data_d     = right_data;
				priority_d = right_priority;
			end
			CELL_REMOVE: begin
				// at or beyond the last matching cell: close the gap
				if (any_match && !later_in) begin
					load       = 1'b1;
					data_d     = right_data;
					priority_d = right_priority;
				end
			end
			CELL_HOLD: begin
				load = 1'b0;
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q     <= data_d;
			priority_q <= priority_d;
		end
	end

endmodule

`default_nettype wire

@@ src/sorted_priority_queue_top.sv @@
// sorted priority queue: top level with controller and the row of cells
// depends on spq_pkg and spq_cell
`default_nettype none

// channel   signals                      direction  carries
// in        in_valid / in_ready          into block operation, item_data, item_priority
// out       out_valid / out_ready        out of block extracted_data, found, status,
//                                                   head_data, head_priority, item_count,
//                                                   queue_empty
//
// rate: one item per cycle unless a result waits; change key makes a remove pass, then an insert pass
// the row of cells and the registered result both update at the accepting edge
// rate is set by the shared broadcast bus: all cells compare and shift at the same edge
// reset: count and handshake state clear at once; cell contents are left as they are
// stalls: a new item is taken in the same cycle the waiting result is taken, not sooner

module sorted_priority_queue_top import spq_pkg::*; #(
	parameter int DEPTH          = DEPTH_DEF,
	parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
	parameter int PRIORITY_WIDTH = PRIORITY_WIDTH_DEF,
	localparam int CW            = $clog2(DEPTH + 1)
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic        [2:0]                operation,
	input  wire logic        [DATA_WIDTH-1:0]     item_data,
	input  wire logic signed [PRIORITY_WIDTH-1:0] item_priority,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic             [DATA_WIDTH-1:0]     extracted_data,
	output logic                                  found,
	output logic             [1:0]                status,
	output logic             [DATA_WIDTH-1:0]     head_data,
	output logic signed      [PRIORITY_WIDTH-1:0] head_priority,
	output logic             [CW-1:0]             item_count,
	output logic                                  queue_empty
);

	// controller state
	state_t  state_q, state_d;
	logic    [CW-1:0] count_q, count_d;
	logic    out_valid_q, out_valid_d;
	logic    [DATA_WIDTH-1:0] extracted_q, extracted_d;
	logic    found_q, found_d;
	status_t status_q, status_d;

	// change key operands held for the insert pass
	logic        [DATA_WIDTH-1:0]     rekey_data_q;
	logic signed [PRIORITY_WIDTH-1:0] rekey_priority_q;

	// broadcast bus to the cells
	cell_op_t                         cell_op;
	logic        [DATA_WIDTH-1:0]     cmd_data;
	logic signed [PRIORITY_WIDTH-1:0] cmd_priority;

	// row of cells
	logic        [DATA_WIDTH-1:0]     cell_data     [DEPTH];
	logic signed [PRIORITY_WIDTH-1:0] cell_priority [DEPTH];
	logic        [DEPTH-1:0]          cell_ge;
	logic        [DEPTH-1:0]          cell_later;

	logic in_fire;
	logic empty;
	logic full;
	logic any_match;
	op_t  op;

	assign op        = op_t'(operation);
	assign empty     = (count_q == '0);
	assign full      = (count_q == CW'(DEPTH));
	assign any_match = cell_later[0];
	assign in_ready  = (state_q == S_RUN) && (!out_valid_q || out_ready);
	assign in_fire   = in_valid && in_ready;

	// operands: live input, or the held pair during the insert pass of change key
	assign cmd_data     = (state_q == S_REKEY) ? rekey_data_q     : item_data;
	assign cmd_priority = (state_q == S_REKEY) ? rekey_priority_q : item_priority;

	// cells, head at index 0, ascending priority, newest first among equals
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		cell_ctl_t                        ctl;
		logic        [DATA_WIDTH-1:0]     l_data;
		logic signed [PRIORITY_WIDTH-1:0] l_priority;
		logic                             l_ge;
		logic        [DATA_WIDTH-1:0]     r_data;
		logic signed [PRIORITY_WIDTH-1:0] r_priority;
		logic                             r_later;

		assign ctl = {cell_op, (CW'(k) < count_q)};

		if (k == 0) begin : g_first
			assign l_data     = '0;
			assign l_priority = '0;
			assign l_ge       = 1'b0;
		end else begin : g_mid
			assign l_data     = cell_data[k-1];
			assign l_priority = cell_priority[k-1];
			assign l_ge       = cell_ge[k-1];
		end

		if (k == DEPTH - 1) begin : g_last
			assign r_data     = '0;
			assign r_priority = '0;
			assign r_later    = 1'b0;
		end else begin : g_inner
			assign r_data     = cell_data[k+1];
			assign r_priority = cell_priority[k+1];
			assign r_later    = cell_later[k+1];
		end

		spq_cell #(
			.DATA_WIDTH     (DATA_WIDTH),
			.PRIORITY_WIDTH (PRIORITY_WIDTH)
		) u_cell (
			.clk            (clk),
			.ctl            (ctl),
			.cmd_data       (cmd_data),
			.cmd_priority   (cmd_priority),
			.left_data      (l_data),
			.left_priority  (l_priority),
			.left_ge        (l_ge),
			.right_data     (r_data),
			.right_priority (r_priority),
			.later_in       (r_later),
			.any_match      (any_match),
			.data_q         (cell_data[k]),
			.priority_q     (cell_priority[k]),
			.ge             (cell_ge[k]),
			.later_out      (cell_later[k])
		);
	end

	// next state, cell command and result fields
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		out_valid_d = out_valid_q && !out_ready;
		extracted_d = extracted_q;
		found_d     = found_q;
		status_d    = status_q;
		cell_op     = CELL_HOLD;
		unique case (state_q)
			S_RUN: begin
				if (in_fire) begin
					extracted_d = '0;
					found_d     = 1'b0;
					status_d    = ST_OK;
					out_valid_d = 1'b1;
					unique case (op)
						OP_INSERT: begin
							if (full) begin
								status_d = ST_FULL;
							end else begin
								cell_op = CELL_INSERT;
								count_d = count_q + 1'b1;
							end
						end
						OP_EXTRACT: begin
							if (empty) begin
								status_d = ST_EMPTY;
							end else begin
								cell_op     = CELL_EXTRACT;
								extracted_d = cell_data[0];
								count_d     = count_q - 1'b1;
							end
						end
						OP_REMOVE: begin
							cell_op = CELL_REMOVE;
							found_d = any_match;
							if (any_match) begin
								count_d = count_q - 1'b1;
							end
						end
						OP_CHANGE: begin
							// remove pass now, insert pass next cycle
							cell_op     = CELL_REMOVE;
							out_valid_d = 1'b0;
							state_d     = S_REKEY;
							if (any_match) begin
								count_d = count_q - 1'b1;
							end
						end
						OP_CONTAINS: begin
							found_d = any_match;
						end
						OP_CLEAR: begin
							count_d = '0;
						end
						default: begin
							cell_op = CELL_HOLD;
						end
					endcase
				end
			end
			S_REKEY: begin
				out_valid_d = 1'b1;
				state_d     = S_RUN;
				if (full) begin
					status_d = ST_FULL;
				end else begin
					cell_op = CELL_INSERT;
					count_d = count_q + 1'b1;
				end
			end
			default: begin
				state_d = S_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RUN;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
		end
	end

	// result fields and held operands carry no reset
	always_ff @(posedge clk) begin
		extracted_q <= extracted_d;
		found_q     <= found_d;
		status_q    <= status_d;
		if (in_fire) begin
			rekey_data_q     <= item_data;
			rekey_priority_q <= item_priority;
		end
	end

	// head read straight from the row, count from the fill counter; neither can move while a result waits
	assign out_valid      = out_valid_q;
	assign extracted_data = extracted_q;
	assign found          = found_q;
	assign status         = status_q;
	assign head_data      = empty ? '0 : cell_data[0];
	assign head_priority  = empty ? '0 : cell_priority[0];
	assign item_count     = count_q;
	assign queue_empty    = empty;

	// fill count never passes the row length
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond depth");

	// no result is offered between the two passes of change key
	a_rekey_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REKEY) |-> !out_valid_q)
		else $error("result offered mid change key");

	// the two front cells stay in order
	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CW'(2)) |-> (cell_priority[0] <= cell_priority[1]))
		else $error("row out of order at head");

	// a successful extract takes exactly one entry
	a_extract_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (op == OP_EXTRACT) && !empty) |=> (count_q == $past(count_q) - 1'b1))
		else $error("extract did not drop one entry");

endmodule

`default_nettype wire

@@ tb/spq_checker.sv @@
// sorted priority queue checker: watches both channels, keeps its own sorted store
// and compares every result against the predicted report; depends on spq_pkg
module spq_checker import spq_pkg::*; (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    in_valid,
	input  wire logic                                    in_ready,
	input  wire logic        [2:0]                       operation,
	input  wire logic        [DATA_WIDTH_DEF-1:0]        item_data,
	input  wire logic signed [PRIORITY_WIDTH_DEF-1:0]    item_priority,
	input  wire logic                                    out_valid,
	input  wire logic                                    out_ready,
	input  wire logic        [DATA_WIDTH_DEF-1:0]        extracted_data,
	input  wire logic                                    found,
	input  wire logic        [1:0]                       status,
	input  wire logic        [DATA_WIDTH_DEF-1:0]        head_data,
	input  wire logic signed [PRIORITY_WIDTH_DEF-1:0]    head_priority,
	input  wire logic        [$clog2(DEPTH_DEF+1)-1:0]   item_count,
	input  wire logic                                    queue_empty,
	output int                                           mismatches,
	output int                                           outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = $clog2(DEPTH_DEF + 1);

	typedef struct packed {
		logic        [31:0]   extracted;
		logic                 found;
		status_t              status;
		logic        [31:0]   head_data;
		logic signed [31:0]   head_pri;
		logic        [CW-1:0] count;
		logic                 empty;
	} queue_report_t;

	// slot 0 holds the largest priority, the head sits at slot held-1
	logic        [31:0] slot_data [DEPTH_DEF];
	logic signed [31:0] slot_pri  [DEPTH_DEF];
	int                 held;
	queue_report_t      reports_due[$];

	// new entry goes head-side of equal priorities, so the newest leaves first
	function automatic status_t place_entry(input logic [31:0] d, input logic signed [31:0] p);
		int i;
		if (held >= DEPTH_DEF)
			return ST_FULL;
		i = held;
		while (i > 0 && p > slot_pri[i-1])
			i--;
		for (int j = held; j > i; j--) begin
			slot_data[j] = slot_data[j-1];
			slot_pri[j]  = slot_pri[j-1];
		end
		slot_data[i] = d;
		slot_pri[i]  = p;
		held++;
		return ST_OK;
	endfunction

	// first match from the far end, i.e. largest priority, earliest inserted
	function automatic logic drop_entry(input logic [31:0] d);
		for (int i = 0; i < held; i++) begin
			if (slot_data[i] == d) begin
				for (int j = i; j + 1 < held; j++) begin
					slot_data[j] = slot_data[j+1];
					slot_pri[j]  = slot_pri[j+1];
				end
				held--;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic logic holds_entry(input logic [31:0] d);
		for (int i = 0; i < held; i++)
			if (slot_data[i] == d)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic queue_report_t step_queue(input logic [2:0] op, input logic [31:0] d,
			input logic signed [31:0] p);
		queue_report_t r;
		r = '0;
		r.status = ST_OK;
		case (op)
			OP_INSERT: r.status = place_entry(d, p);
			OP_EXTRACT: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.extracted = slot_data[held-1];
					held--;
				end
			end
			OP_REMOVE: r.found = drop_entry(d);
			OP_CHANGE: begin
				void'(drop_entry(d));
				r.status = place_entry(d, p);
			end
			OP_CONTAINS: r.found = holds_entry(d);
			OP_CLEAR: held = 0;
			default: ;
		endcase
		if (held > 0) begin
			r.head_data = slot_data[held-1];
			r.head_pri  = slot_pri[held-1];
		end
		r.count = CW'(held);
		r.empty = (held == 0);
		return r;
	endfunction

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		queue_report_t want;
		if (!arst_n) begin
			held = 0;
			mismatches = 0;
			reports_due.delete();
			outstanding <= 0;
		end else begin
			// a result leaving now belongs to an earlier item, so check before predicting
			if (out_valid && out_ready) begin
				if (reports_due.size() == 0) begin
					$error("result arrived with no item waiting for one");
					mismatches++;
				end else begin
					want = reports_due.pop_front();
					check_field("extracted_data", want.extracted, extracted_data);
					check_field("found", 32'(want.found), 32'(found));
					check_field("status", 32'(want.status), 32'(status));
					check_field("head_data", want.head_data, head_data);
					check_field("head_priority", want.head_pri, head_priority);
					check_field("item_count", 32'(want.count), 32'(item_count));
					check_field("queue_empty", 32'(want.empty), 32'(queue_empty));
				end
			end
			if (in_valid && in_ready)
				reports_due.push_back(step_queue(operation, item_data, item_priority));
			outstanding <= reports_due.size();
		end
	end

endmodule

@@ tb/sorted_priority_queue_top_tb.sv @@
// sorted priority queue testbench top: clock, reset, stimulus, receiver stalls and verdict
// depends on spq_pkg, sorted_priority_queue_top and spq_checker
module sorted_priority_queue_top_tb import spq_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = $clog2(DEPTH_DEF + 1);

	// codes six and seven do nothing in the block but still return a report
	localparam logic [2:0] OP_UNUSED_LO = 3'd6;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	localparam logic [31:0] MAX_PRI = 32'h7FFF_FFFF;
	localparam logic [31:0] MIN_PRI = 32'h8000_0000;

	localparam int N_RANDOM   = 1870;
	localparam int SEGMENT    = 48;   // items per load mode
	localparam int LONG_HOLD  = 60;   // receiver hold-off for the back-pressure check
	localparam int QUIET_MAX  = 2000; // cycles with no item moving before giving up
	localparam int DRAIN_WAIT = 8;

	typedef enum logic [1:0] {
		MODE_FILL,
		MODE_DRAIN,
		MODE_MIX
	} load_mode_t;

	logic                                  clk           = 1'b0;
	logic                                  arst_n        = 1'b0;
	logic                                  in_valid      = 1'b0;
	logic                                  in_ready;
	logic        [2:0]                     operation     = '0;
	logic        [DATA_WIDTH_DEF-1:0]      item_data     = '0;
	logic signed [PRIORITY_WIDTH_DEF-1:0]  item_priority = '0;
	logic                                  out_valid;
	logic                                  out_ready     = 1'b0;
	logic        [DATA_WIDTH_DEF-1:0]      extracted_data;
	logic                                  found;
	logic        [1:0]                     status;
	logic        [DATA_WIDTH_DEF-1:0]      head_data;
	logic signed [PRIORITY_WIDTH_DEF-1:0]  head_priority;
	logic        [CW-1:0]                  item_count;
	logic                                  queue_empty;

	int          mismatches;
	int          outstanding;
	int          quiet_cycles = 0;
	bit          sender_calm  = 1'b0;
	bit          squeeze_pending = 1'b0;
	logic [31:0] data_pool[8];

	sorted_priority_queue_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .item_data(item_data), .item_priority(item_priority),
		.out_valid(out_valid), .out_ready(out_ready),
		.extracted_data(extracted_data), .found(found), .status(status),
		.head_data(head_data), .head_priority(head_priority),
		.item_count(item_count), .queue_empty(queue_empty)
	);

	spq_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .item_data(item_data), .item_priority(item_priority),
		.out_valid(out_valid), .out_ready(out_ready),
		.extracted_data(extracted_data), .found(found), .status(status),
		.head_data(head_data), .head_priority(head_priority),
		.item_count(item_count), .queue_empty(queue_empty),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// mostly back-to-back, sometimes a short gap, rarely a long pause
	function automatic int idle_len(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// a small pool of data words keeps remove, contains and change key hitting
	function automatic logic [31:0] pick_data();
		if ($urandom_range(0, 99) < 85)
			return data_pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	// narrow range gives plenty of ties, full range and the extremes the rest
	function automatic logic [31:0] pick_priority();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return 32'($urandom_range(0, 8)) - 32'd4;
		if (r < 75)
			return $urandom;
		if (r < 85)
			return $urandom_range(0, 1) ? MAX_PRI : MIN_PRI;
		return $urandom_range(0, 1) ? MAX_PRI - 32'd1 : MIN_PRI + 32'd1;
	endfunction

	// load mode steers the fill level so that both full and empty get visited
	function automatic logic [2:0] pick_op(input load_mode_t mode);
		int ins;
		int ext;
		int r;
		case (mode)
			MODE_FILL:  begin ins = 55; ext = 12; end
			MODE_DRAIN: begin ins = 20; ext = 50; end
			default:    begin ins = 35; ext = 25; end
		endcase
		r = $urandom_range(0, 99);
		if (r < ins)
			return OP_INSERT;
		if (r < ins + ext)
			return OP_EXTRACT;
		r = $urandom_range(0, 99);
		if (r < 30)
			return OP_REMOVE;
		if (r < 58)
			return OP_CHANGE;
		if (r < 90)
			return OP_CONTAINS;
		if (r < 95)
			return OP_CLEAR;
		return $urandom_range(0, 1) ? OP_UNUSED_HI : OP_UNUSED_LO;
	endfunction

	// present one item and hold it until the block takes it; valid only drops
	// when an idle gap follows, so it is never lowered and raised in one step
	task automatic offer(input logic [2:0] op, input logic [31:0] d, input logic [31:0] p);
		int gap;
		gap = idle_len(sender_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		operation     <= op;
		item_data     <= d;
		item_priority <= p;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// receiver: random ready gaps, calm stretches, and the odd long hold-off
	// on request so that the block fills and pushes back on its input
	initial begin
		bit calm;
		int gap;
		calm = 1'b0;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 15) == 0)
				calm = !calm;
			if (squeeze_pending) begin
				squeeze_pending = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				gap = idle_len(calm);
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	// watchdog: nothing moving on either channel for too long ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_MAX) begin
				$display("** sorted_priority_queue_top: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		load_mode_t mode;
		foreach (data_pool[i])
			data_pool[i] = $urandom;
		mode = MODE_MIX;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty extract, extreme fields, ties, full queue, hits and misses
		offer(OP_EXTRACT, 32'h0, 32'h0);
		offer(OP_INSERT, 32'hFFFF_FFFF, MAX_PRI);
		offer(OP_INSERT, 32'h0, MIN_PRI);
		offer(OP_INSERT, 32'hA1, 32'd5);
		offer(OP_INSERT, 32'hA2, 32'd5);
		offer(OP_INSERT, 32'hA3, 32'd5);
		// fill to the brim with a repeated data word, one more tie at five on the end
		for (int k = 0; k < 11; k++)
			offer(OP_INSERT, 32'h1, 32'(k) - 32'd5);
		offer(OP_INSERT, 32'h55, 32'h0);
		offer(OP_CHANGE, 32'h66, 32'd3);
		offer(OP_CHANGE, 32'hA2, 32'hFFFF_FFF9);
		offer(OP_CONTAINS, 32'hFFFF_FFFF, 32'h0);
		offer(OP_CONTAINS, 32'h77, 32'h0);
		// several entries carry this word: the one farthest from the head goes
		offer(OP_REMOVE, 32'h1, 32'h0);
		offer(OP_REMOVE, 32'h77, 32'h0);
		offer(OP_EXTRACT, 32'h0, 32'h0);
		offer(OP_UNUSED_LO, 32'hFFFF_FFFF, MAX_PRI);
		offer(OP_UNUSED_HI, 32'h0, MIN_PRI);
		offer(OP_CLEAR, 32'h0, 32'h0);

		// random: segments of fill, drain or mixed load with fresh pool words
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % SEGMENT == 0) begin
				mode = load_mode_t'($urandom_range(0, 2));
				sender_calm = ($urandom_range(0, 3) == 0);
				data_pool[$urandom_range(0, 7)] = $urandom;
			end
			if (n == 300 || n == 1200)
				squeeze_pending = 1'b1;
			offer(pick_op(mode), pick_data(), pick_priority());
		end
		in_valid <= 1'b0;

		// let the checker count the last item before waiting on it
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("** sorted_priority_queue_top: PASSED **");
		else
			$display("** sorted_priority_queue_top: FAILED **");
		$finish;
	end

endmodule
